FILE: rtl/core/same_length_fir_convolver_macros.svh
// Assertion macros shared by the same-length FIR convolver RTL.
// The macros expect signals named clock and reset in the using scope.
`ifndef SAME_LENGTH_FIR_CONVOLVER_MACROS_SVH
`define SAME_LENGTH_FIR_CONVOLVER_MACROS_SVH

// Checks that prop holds in the same cycle as cond.
`define SLFC_ASSERT_NOW(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("same_length_fir_convolver: check failed");

// Checks that prop holds in the cycle after cond.
`define SLFC_ASSERT_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("same_length_fir_convolver: check failed");

`endif

FILE: rtl/core/slfc_pkg.sv
// Package for the same-length FIR convolver: field widths, action codes,
// parameter defaults and the result type. No dependencies.
`timescale 1ns / 1ps

package slfc_pkg;

   localparam int MAX_TAPS_DEF     = 64;
   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int COEF_WIDTH_DEF   = 16;

   localparam int VALUE_W     = 16;
   localparam int INDEX_W     = 6;
   localparam int TAP_COUNT_W = 7;
   localparam int RESULT_W    = 38;

   localparam logic ACTION_LOAD   = 1'b0;
   localparam logic ACTION_SAMPLE = 1'b1;

   typedef logic signed [RESULT_W-1:0] result_type;

endpackage

FILE: rtl/core/slfc_req_if.sv
// Input channel of the FIR convolver: one load or sample word per handshake.
// Depends on slfc_pkg for the field widths.
`timescale 1ns / 1ps

interface slfc_req_if;
   logic                                valid;
   logic                                ready;
   logic                                action;
   logic [slfc_pkg::INDEX_W-1:0]        coef_index;
   logic signed [slfc_pkg::VALUE_W-1:0] value;
   logic                                last;

   modport source (output valid, action, coef_index, value, last, input ready);
   modport sink (input valid, action, coef_index, value, last, output ready);
endinterface

FILE: rtl/core/slfc_rsp_if.sv
// Result channel of the FIR convolver: one convolution sum per handshake.
// Depends on slfc_pkg for the result type.
`timescale 1ns / 1ps

interface slfc_rsp_if;
   logic                 valid;
   logic                 ready;
   slfc_pkg::result_type result;
   logic                 result_last;

   modport source (output valid, result, result_last, input ready);
   modport sink (input valid, result, result_last, output ready);
endinterface

FILE: rtl/core/slfc_csr_if.sv
// Configuration write channel of the FIR convolver, carrying the tap count.
// Depends on slfc_pkg for the register width.
`timescale 1ns / 1ps

interface slfc_csr_if;
   logic                             valid;
   logic                             ready;
   logic [slfc_pkg::TAP_COUNT_W-1:0] tap_count;

   modport source (output valid, tap_count, input ready);
   modport sink (input valid, tap_count, output ready);
endinterface

FILE: rtl/core/slfc_add_tree.sv
// Pipelined adder tree of the FIR convolver: registers the lane products, then
// halves them with one registered add level per stage. Depends on slfc_pkg.
`timescale 1ns / 1ps

module slfc_add_tree #(
   parameter int LEVELS = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  slfc_pkg::result_type in_lanes [2**LEVELS],
   input  logic                 in_last,
   output logic                 out_valid,
   input  logic                 out_ready,
   output slfc_pkg::result_type out_sum,
   output logic                 out_last
);

   localparam int LANES = 2**LEVELS;
   localparam int NODES = 2 * LANES - 1;

   // Stage s occupies nodes from 2*LANES - (2*LANES >> s), LANES >> s of them.
   slfc_pkg::result_type node_ff [NODES];
   logic [LEVELS:0]      valid_ff;
   logic [LEVELS:0]      last_ff;
   logic [LEVELS+1:0]    stage_ready;

   // A stage takes a new word when it is empty or its word moves on.
   assign stage_ready[LEVELS+1] = out_ready;
   for (genvar s = 0; s <= LEVELS; s++) begin : g_ready
      assign stage_ready[s] = !valid_ff[s] || stage_ready[s+1];
   end

   assign in_ready  = stage_ready[0];
   assign out_valid = valid_ff[LEVELS];
   assign out_last  = last_ff[LEVELS];
   assign out_sum   = node_ff[NODES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         last_ff  <= '0;
      end else begin
         if (stage_ready[0]) begin
            valid_ff[0] <= in_valid;
            last_ff[0]  <= in_last;
         end
         for (int s = 1; s <= LEVELS; s++) begin
            if (stage_ready[s]) begin
               valid_ff[s] <= valid_ff[s-1];
               last_ff[s]  <= last_ff[s-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[0]) begin
         for (int i = 0; i < LANES; i++) begin
            node_ff[i] <= in_lanes[i];
         end
      end
      for (int s = 1; s <= LEVELS; s++) begin
         if (stage_ready[s]) begin
            for (int i = 0; i < (LANES >> s); i++) begin
               node_ff[2*LANES - (2*LANES >> s) + i] <=
                  node_ff[2*LANES - (2*LANES >> (s-1)) + 2*i] +
                  node_ff[2*LANES - (2*LANES >> (s-1)) + 2*i + 1];
            end
         end
      end
   end

endmodule

FILE: rtl/core/same_length_fir_convolver.sv
// Same-length FIR convolver (matched filter), top level; uses slfc_pkg, the three
// channel interfaces and slfc_add_tree. Load words write one coefficient, sample
// words shift the delay line, and every lane multiplies its coefficient by its
// delay-line tap in the cycle after acceptance; a registered adder tree of
// log2(MAX_TAPS) add stages then forms the exact sum. Outside a flush, a word is taken
// every clock while results drain; a result passes the delay-line register, the
// product register and the add stages in turn after its sample. A sample marked last
// holds req ready low while the flush sequencer shifts lead = m - 1 - floor(m/2)
// zeros into the delay line and emits the zero-padded tail, then clears the delay
// line and the sample count; a stalled rsp lengthens this. The coefficient store has
// no reset and must be written before its entries are used. The user writes the tap
// count on the csr channel only while idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`include "same_length_fir_convolver_macros.svh"

module same_length_fir_convolver #(
   parameter int MAX_TAPS     = slfc_pkg::MAX_TAPS_DEF,
   parameter int SAMPLE_WIDTH = slfc_pkg::SAMPLE_WIDTH_DEF,
   parameter int COEF_WIDTH   = slfc_pkg::COEF_WIDTH_DEF
) (
   input logic         clock,
   input logic         reset,
   slfc_req_if.sink    req_if,
   slfc_rsp_if.source  rsp_if,
   slfc_csr_if.sink    csr_if
);

   localparam int CNT_W  = $clog2(MAX_TAPS + 1);
   localparam int LEVELS = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int LANES  = 2**LEVELS;
   localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;

   logic [slfc_pkg::TAP_COUNT_W-1:0] tap_count_ff;

   logic signed [SAMPLE_WIDTH-1:0] hist_ff [MAX_TAPS];
   logic signed [SAMPLE_WIDTH-1:0] hist_in [MAX_TAPS];
   logic signed [COEF_WIDTH-1:0]   coef_ff [MAX_TAPS];
   logic signed [SAMPLE_WIDTH-1:0] sample_in;
   logic signed [COEF_WIDTH-1:0]   coef_in;

   logic             p0_valid_ff, p0_valid_in;
   logic             p0_last_ff, p0_last_in;
   logic             flush_ff, flush_in;
   logic [CNT_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0] lead_ff, lead_in;
   logic [CNT_W-1:0] skip_ff, skip_in;
   logic [CNT_W-1:0] seen_ff, seen_in;

   logic [CNT_W-1:0] taps_used;
   logic [CNT_W-1:0] lead_now;
   logic [CNT_W-1:0] skip_now;
   logic [CNT_W-1:0] step_next;

   logic tree_in_ready;
   logic p0_free, p0_adv;
   logic accept, sample_shift, coef_load, gen_step, clear_now;

   slfc_pkg::result_type lane_prod [LANES];

   // Fields wider than the 16-bit value take it zero-extended.
   if (SAMPLE_WIDTH <= slfc_pkg::VALUE_W) begin : g_sample_narrow
      assign sample_in = req_if.value[SAMPLE_WIDTH-1:0];
   end else begin : g_sample_wide
      assign sample_in = {{(SAMPLE_WIDTH - slfc_pkg::VALUE_W){1'b0}}, req_if.value};
   end
   if (COEF_WIDTH <= slfc_pkg::VALUE_W) begin : g_coef_narrow
      assign coef_in = req_if.value[COEF_WIDTH-1:0];
   end else begin : g_coef_wide
      assign coef_in = {{(COEF_WIDTH - slfc_pkg::VALUE_W){1'b0}}, req_if.value};
   end

   // Configuration.
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= slfc_pkg::TAP_COUNT_W'(1);
      end else if (csr_if.valid) begin
         tap_count_ff <= csr_if.tap_count;
      end
   end

   always_comb begin
      if (tap_count_ff == '0) begin
         taps_used = CNT_W'(1);
      end else if (32'(tap_count_ff) > MAX_TAPS) begin
         taps_used = CNT_W'(MAX_TAPS);
      end else begin
         taps_used = CNT_W'(tap_count_ff);
      end
   end

   assign lead_now  = taps_used - CNT_W'(1) - (taps_used >> 1);
   // Zero shifts at the start of a flush that yield no result (short signals).
   assign skip_now  = (seen_ff < lead_now) ? (lead_now - seen_ff) : '0;
   assign step_next = step_ff + CNT_W'(1);

   // Handshake and sequencing.
   assign p0_free      = !p0_valid_ff || tree_in_ready;
   assign p0_adv       = p0_valid_ff && tree_in_ready;
   assign req_if.ready = !flush_ff && p0_free;
   assign accept       = req_if.valid && req_if.ready;
   assign sample_shift = accept && (req_if.action == slfc_pkg::ACTION_SAMPLE);
   assign coef_load    = accept && (req_if.action == slfc_pkg::ACTION_LOAD);
   assign gen_step     = flush_ff && (step_ff != lead_ff) && p0_free;
   assign clear_now    = p0_adv && p0_last_ff;

   always_comb begin
      p0_valid_in = p0_valid_ff;
      p0_last_in  = p0_last_ff;
      flush_in    = flush_ff;
      step_in     = step_ff;
      lead_in     = lead_ff;
      skip_in     = skip_ff;
      seen_in     = seen_ff;
      if (p0_adv) begin
         p0_valid_in = 1'b0;
      end
      if (sample_shift) begin
         if (req_if.last) begin
            p0_valid_in = (skip_now == '0);
            p0_last_in  = (lead_now == '0);
            flush_in    = 1'b1;
            step_in     = '0;
            lead_in     = lead_now;
            skip_in     = skip_now;
         end else begin
            p0_valid_in = (seen_ff >= lead_now);
            p0_last_in  = 1'b0;
            if (seen_ff != '1) begin
               seen_in = seen_ff + CNT_W'(1);
            end
         end
      end else if (gen_step) begin
         p0_valid_in = (step_next >= skip_ff);
         p0_last_in  = (step_next == lead_ff);
         step_in     = step_next;
      end
      if (clear_now) begin
         flush_in = 1'b0;
         step_in  = '0;
         seen_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_valid_ff <= 1'b0;
         p0_last_ff  <= 1'b0;
         flush_ff    <= 1'b0;
         step_ff     <= '0;
         seen_ff     <= '0;
      end else begin
         p0_valid_ff <= p0_valid_in;
         p0_last_ff  <= p0_last_in;
         flush_ff    <= flush_in;
         step_ff     <= step_in;
         seen_ff     <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      lead_ff <= lead_in;
      skip_ff <= skip_in;
   end

   // Delay line, newest sample at tap 0. Flush steps shift in zeros.
   always_comb begin
      hist_in = hist_ff;
      if (clear_now) begin
         for (int t = 0; t < MAX_TAPS; t++) begin
            hist_in[t] = '0;
         end
      end else if (sample_shift || gen_step) begin
         hist_in[0] = gen_step ? '0 : sample_in;
         for (int t = 1; t < MAX_TAPS; t++) begin
            hist_in[t] = hist_ff[t-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '{default: '0};
      end else begin
         hist_ff <= hist_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int t = 0; t < MAX_TAPS; t++) begin
         if (coef_load && (32'(req_if.coef_index) == t)) begin
            coef_ff[t] <= coef_in;
         end
      end
   end

   // Coefficient t meets the sample t positions behind the newest one.
   for (genvar t = 0; t < LANES; t++) begin : g_lane
      if (t < MAX_TAPS) begin : g_tap
         logic signed [PROD_W-1:0] prod;
         assign prod = PROD_W'(coef_ff[t]) * PROD_W'(hist_ff[t]);
         assign lane_prod[t] = (32'(taps_used) > t) ? slfc_pkg::result_type'(prod) : '0;
      end else begin : g_pad
         assign lane_prod[t] = '0;
      end
   end

   slfc_add_tree #(
      .LEVELS (LEVELS)
   ) u_add_tree (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p0_valid_ff),
      .in_ready  (tree_in_ready),
      .in_lanes  (lane_prod),
      .in_last   (p0_last_ff),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_sum   (rsp_if.result),
      .out_last  (rsp_if.result_last)
   );

   `SLFC_ASSERT_NEXT(a_clear_after_final, p0_adv && p0_last_ff, seen_ff == '0 && !flush_ff && hist_ff[0] == '0)
   `SLFC_ASSERT_NOW(a_step_bounded, flush_ff, step_ff <= lead_ff)
   `SLFC_ASSERT_NOW(a_final_after_steps, p0_valid_ff && p0_last_ff, flush_ff && step_ff == lead_ff)

endmodule

FILE: tb/slfc_fir_checker.sv
// Checker for the same-length FIR convolver: watches the three channels, predicts
// every result word and compares it with what the block returns.
// Depends on slfc_pkg and the slfc_req_if, slfc_rsp_if and slfc_csr_if interfaces.
`timescale 1ns / 1ps

module slfc_fir_checker (
   input  logic clock,
   input  logic reset,
   slfc_req_if  req_if,
   slfc_rsp_if  rsp_if,
   slfc_csr_if  csr_if,
   output int   fail_count,
   output int   pending_results
);

   localparam int TAPS        = slfc_pkg::MAX_TAPS_DEF;
   localparam int VALUE_W     = slfc_pkg::VALUE_W;
   localparam int INDEX_W     = slfc_pkg::INDEX_W;
   localparam int TAP_COUNT_W = slfc_pkg::TAP_COUNT_W;
   localparam int RESULT_W    = slfc_pkg::RESULT_W;
   localparam int SEEN_MAX    = 127;

   typedef struct packed {
      slfc_pkg::result_type sum;
      logic                 last;
   } fir_output_type;

   logic signed [VALUE_W-1:0] coef_mem [TAPS];
   logic signed [VALUE_W-1:0] history  [TAPS];
   logic [TAP_COUNT_W-1:0]    tap_reg = TAP_COUNT_W'(1);
   int                        seen_count = 0;
   int                        mismatches = 0;
   int                        waiting = 0;
   fir_output_type            expected_sums [$];

   assign fail_count      = mismatches;
   assign pending_results = waiting;

   initial begin
      foreach (history[i]) history[i] = '0;
      foreach (coef_mem[i]) coef_mem[i] = '0;
   end

   function automatic int active_taps();
      int m;
      m = int'(tap_reg);
      if (m < 1) m = 1;
      if (m > TAPS) m = TAPS;
      return m;
   endfunction

   // Sum for the output that lies behind positions back from the newest sample.
   function automatic slfc_pkg::result_type window_sum(int m, int behind);
      int     age;
      longint acc;
      acc = 0;
      for (int j = 0; j < m; j++) begin
         age = behind + m / 2 - j;
         if (age >= 0 && age < TAPS)
            acc += longint'(history[age]) * longint'(coef_mem[m - 1 - j]);
      end
      return acc[RESULT_W-1:0];
   endfunction

   task automatic push_expected(slfc_pkg::result_type sum, logic last);
      fir_output_type item;
      item.sum  = sum;
      item.last = last;
      expected_sums.push_back(item);
   endtask

   task automatic predict_word(logic action, logic [INDEX_W-1:0] idx,
                               logic signed [VALUE_W-1:0] val, logic is_last);
      int m;
      int lead;
      int first;
      if (action == slfc_pkg::ACTION_LOAD) begin
         coef_mem[idx] = val;
      end else begin
         for (int i = TAPS - 1; i > 0; i--) history[i] = history[i - 1];
         history[0] = val;
         m    = active_taps();
         lead = m - 1 - m / 2;
         if (!is_last) begin
            if (seen_count >= lead) push_expected(window_sum(m, lead), 1'b0);
            if (seen_count < SEEN_MAX) seen_count++;
         end else begin
            // The flush emits every output still owed, oldest first.
            first = (seen_count < lead) ? seen_count : lead;
            for (int d = first; d >= 0; d--) push_expected(window_sum(m, d), d == 0);
            foreach (history[i]) history[i] = '0;
            seen_count = 0;
         end
      end
   endtask

   always @(posedge clock) begin : monitor
      fir_output_type want;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_sums.size() == 0) begin
               $display("%0t: result %0d last %0b arrived with none expected",
                        $time, rsp_if.result, rsp_if.result_last);
               mismatches++;
            end else begin
               want = expected_sums.pop_front();
               if (rsp_if.result !== want.sum) begin
                  $display("%0t: result mismatch: expected %0d, actual %0d",
                           $time, want.sum, rsp_if.result);
                  mismatches++;
               end
               if (rsp_if.result_last !== want.last) begin
                  $display("%0t: result_last mismatch: expected %0b, actual %0b",
                           $time, want.last, rsp_if.result_last);
                  mismatches++;
               end
            end
         end
         if (csr_if.valid && csr_if.ready) tap_reg = csr_if.tap_count;
         if (req_if.valid && req_if.ready)
            predict_word(req_if.action, req_if.coef_index, req_if.value, req_if.last);
         waiting = expected_sums.size();
      end
   end

endmodule

FILE: tb/same_length_fir_convolver_tb.sv
// Top of the FIR convolver testbench: clock, reset, stimulus and the verdict.
// Depends on slfc_pkg, the channel interfaces, the block and slfc_fir_checker.
`timescale 1ns / 1ps

module same_length_fir_convolver_tb;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 50;
   localparam int RANDOM_ITEMS  = 110;

   localparam int VALUE_W     = slfc_pkg::VALUE_W;
   localparam int INDEX_W     = slfc_pkg::INDEX_W;
   localparam int TAP_COUNT_W = slfc_pkg::TAP_COUNT_W;

   localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W - 1){1'b1}}};
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W - 1){1'b0}}};
   localparam logic [INDEX_W-1:0]        INDEX_MAX = {INDEX_W{1'b1}};
   localparam logic [TAP_COUNT_W-1:0]    TAP_MAX   = {TAP_COUNT_W{1'b1}};

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   full_rate = 1'b0;
   int   fail_count;
   int   pending_results;
   int   cycle_count = 0;
   int   issued = 0;

   slfc_req_if req_ch ();
   slfc_rsp_if rsp_ch ();
   slfc_csr_if csr_ch ();

   same_length_fir_convolver u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   slfc_fir_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_if          (req_ch),
      .rsp_if          (rsp_ch),
      .csr_if          (csr_ch),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Mostly short gaps, now and then a long one; none while running at full rate.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (full_rate || roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return VALUE_MIN;
         1: return VALUE_MAX;
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   task automatic send_word(logic action, logic [INDEX_W-1:0] idx,
                            logic signed [VALUE_W-1:0] val, logic is_last);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid      = 1'b1;
      req_ch.action     = action;
      req_ch.coef_index = idx;
      req_ch.value      = val;
      req_ch.last       = is_last;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Holds the sender off until every expected word has come and the block is quiet.
   task automatic go_idle();
      @(negedge clock);
      req_ch.valid = 1'b0;
      wait (pending_results == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_taps(logic [TAP_COUNT_W-1:0] taps);
      go_idle();
      csr_ch.valid     = 1'b1;
      csr_ch.tap_count = taps;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   // A signal with random content, sprinkled with coefficient loads and pauses.
   task automatic send_signal(int len, logic terminate);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            send_word(slfc_pkg::ACTION_LOAD, INDEX_W'($urandom), pick_value(),
                      1'($urandom));
            issued++;
         end
         if ($urandom_range(0, 39) == 0) go_idle();
         send_word(slfc_pkg::ACTION_SAMPLE, INDEX_W'($urandom), pick_value(),
                   terminate && (i == len - 1));
         issued++;
      end
   endtask

   initial begin : result_sink
      int stall;
      rsp_ch.ready = 1'b0;
      forever begin
         if (full_rate) begin
            rsp_ch.ready = 1'b1;
            @(negedge clock);
         end else begin
            stall = pick_gap();
            if (stall > 0) begin
               rsp_ch.ready = 1'b0;
               repeat (stall) @(negedge clock);
            end
            rsp_ch.ready = 1'b1;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
   end

   initial begin : stimulus
      logic [TAP_COUNT_W-1:0] taps;
      req_ch.valid      = 1'b0;
      req_ch.action     = slfc_pkg::ACTION_LOAD;
      req_ch.coef_index = '0;
      req_ch.value      = '0;
      req_ch.last       = 1'b0;
      csr_ch.valid      = 1'b0;
      csr_ch.tap_count  = TAP_COUNT_W'(1);
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // The whole coefficient store is written before any sample reads it.
      for (int i = 0; i < slfc_pkg::MAX_TAPS_DEF; i++)
         send_word(slfc_pkg::ACTION_LOAD, INDEX_W'(i), pick_value(), 1'b0);
      send_word(slfc_pkg::ACTION_LOAD, '0, VALUE_MIN, 1'b1);
      send_word(slfc_pkg::ACTION_LOAD, INDEX_MAX, VALUE_MAX, 1'b0);

      // One tap after reset: each word comes straight back scaled.
      send_word(slfc_pkg::ACTION_SAMPLE, '0, VALUE_MAX, 1'b0);
      send_word(slfc_pkg::ACTION_SAMPLE, INDEX_MAX, VALUE_MIN, 1'b0);
      send_word(slfc_pkg::ACTION_SAMPLE, '0, -16'sd1, 1'b1);

      // Full width: a single-sample signal, then one that ends before the lead.
      write_taps(7'd64);
      send_word(slfc_pkg::ACTION_SAMPLE, '0, VALUE_MIN, 1'b1);
      send_word(slfc_pkg::ACTION_SAMPLE, '0, VALUE_MIN, 1'b0);
      send_word(slfc_pkg::ACTION_SAMPLE, '0, VALUE_MAX, 1'b0);
      send_word(slfc_pkg::ACTION_SAMPLE, '0, 16'sd1, 1'b1);

      // A tap count of zero acts as one.
      write_taps('0);
      send_word(slfc_pkg::ACTION_SAMPLE, '0, VALUE_MAX, 1'b0);
      send_word(slfc_pkg::ACTION_SAMPLE, '0, VALUE_MIN, 1'b1);

      // Above the maximum acts as the maximum; the count then changes mid-signal.
      write_taps(TAP_MAX);
      send_word(slfc_pkg::ACTION_SAMPLE, '0, VALUE_MIN, 1'b0);
      send_word(slfc_pkg::ACTION_SAMPLE, '0, VALUE_MIN, 1'b0);
      send_word(slfc_pkg::ACTION_SAMPLE, '0, VALUE_MAX, 1'b0);
      write_taps(7'd3);
      send_word(slfc_pkg::ACTION_SAMPLE, '0, VALUE_MAX, 1'b0);
      send_word(slfc_pkg::ACTION_SAMPLE, '0, VALUE_MIN, 1'b1);

      issued = 0;
      while (issued < RANDOM_ITEMS) begin
         case ($urandom_range(0, 7))
            0: taps = 7'd1;
            1: taps = 7'd2;
            2: taps = 7'd64;
            3: taps = '0;
            4: taps = 7'($urandom_range(65, 127));
            default: taps = 7'($urandom_range(1, 64));
         endcase
         write_taps(taps);
         full_rate = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(2, 4)) send_signal($urandom_range(1, 40), 1'b1);
         // Sometimes the signal stays open across the next tap count change.
         if ($urandom_range(0, 3) == 0) send_signal($urandom_range(1, 20), 1'b0);
         full_rate = 1'b0;
      end

      go_idle();
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/slfc_pkg.sv
rtl/core/slfc_req_if.sv
rtl/core/slfc_rsp_if.sv
rtl/core/slfc_csr_if.sv
rtl/core/slfc_add_tree.sv
rtl/core/same_length_fir_convolver.sv
tb/slfc_fir_checker.sv
tb/same_length_fir_convolver_tb.sv
